>>> rtl/tsd_pkg.sv
`default_nettype none
package tsd_pkg;

  localparam int COORD_W         = 32;
  localparam int DEPTH_LIMIT_DEF = 4;
  localparam int CFG_ADDR_W      = 4;

  localparam logic [23:0] MIN_EDGE_RST = 24'd0;
  localparam logic [19:0] SAFE_RST     = 20'd0;
  localparam logic [15:0] MARGIN_RST   = 16'd2458;
  localparam logic [13:0] SOURCE_RST   = 14'd5816;

  typedef enum logic [1:0] {
    REG_MIN_EDGE,
    REG_SAFE_PER_EDGE,
    REG_MARGIN,
    REG_REACH_SCALE
  } tsd_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  function automatic logic [63:0] sat_sum3(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] c);
    logic [65:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    return (|s[65:64]) ? '1 : s[63:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/tsd_front.sv
`default_nettype none
module tsd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire tsd_pkg::coord_t eye [3],
  input  wire tsd_pkg::coord_t va  [3],
  input  wire tsd_pkg::coord_t vb  [3],
  input  wire tsd_pkg::coord_t vc  [3],
  input  wire logic [45:0]     reach2,
  output logic                 out_valid,
  output logic                 far,
  output logic [63:0]          e2max,
  output logic [25:0]          d2hi
);
  import tsd_pkg::*;

  logic [4:0] vld;

  coord_t            eye1 [3];
  coord_t            lo1  [3];
  coord_t            hi1  [3];
  logic signed [32:0] ed1 [9];
  coord_t            lo_c [3];
  coord_t            hi_c [3];

  logic [31:0] q2  [3];
  logic [31:0] ea2 [9];
  logic [63:0] sq3d [3];
  logic [63:0] sq3e [9];
  logic [63:0] d24;
  logic [63:0] e24 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_c[i] = va[i];
      hi_c[i] = va[i];
      if (vb[i] < lo_c[i]) lo_c[i] = vb[i];
      if (vb[i] > hi_c[i]) hi_c[i] = vb[i];
      if (vc[i] < lo_c[i]) lo_c[i] = vc[i];
      if (vc[i] > hi_c[i]) hi_c[i] = vc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye1[i]  <= eye[i];
        lo1[i]   <= lo_c[i];
        hi1[i]   <= hi_c[i];
        ed1[i]   <= 33'(va[i]) - 33'(vb[i]);
        ed1[3+i] <= 33'(vb[i]) - 33'(vc[i]);
        ed1[6+i] <= 33'(vc[i]) - 33'(va[i]);
      end
      for (int i = 0; i < 3; i++) begin
        if (eye1[i] < lo1[i]) begin
          q2[i] <= 32'(33'(lo1[i]) - 33'(eye1[i]));
        end else if (eye1[i] > hi1[i]) begin
          q2[i] <= 32'(33'(eye1[i]) - 33'(hi1[i]));
        end else begin
          q2[i] <= '0;
        end
      end
      for (int i = 0; i < 9; i++) begin
        ea2[i] <= ed1[i][32] ? 32'(-ed1[i]) : ed1[i][31:0];
      end
      for (int i = 0; i < 3; i++) begin
        sq3d[i] <= 64'(q2[i]) * 64'(q2[i]);
      end
      for (int i = 0; i < 9; i++) begin
        sq3e[i] <= 64'(ea2[i]) * 64'(ea2[i]);
      end
      d24 <= sat_sum3(sq3d[0], sq3d[1], sq3d[2]);
      for (int j = 0; j < 3; j++) begin
        e24[j] <= sat_sum3(sq3e[3*j], sq3e[3*j+1], sq3e[3*j+2]);
      end
      far  <= d24 >= {18'b0, reach2};
      d2hi <= d24[45:20];
      if (e24[1] > e24[0] && e24[1] >= e24[2]) begin
        e2max <= e24[1];
      end else if (e24[2] > e24[0]) begin
        e2max <= e24[2];
      end else begin
        e2max <= e24[0];
      end
    end
  end

  assign out_valid = vld[4];

endmodule
`default_nettype wire

>>> rtl/tsd_isqrt.sv
`default_nettype none
module tsd_isqrt #(
  parameter int W  = 64,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [W-1:0]  in_x,
  input  wire logic [SW-1:0] in_sb,
  output logic [W/2-1:0]     root,
  output logic [SW-1:0]      out_sb
);
  localparam int N = W / 2;

  logic [W-1:0]  x_s    [N+1];
  logic [N+1:0]  rem_s  [N+1];
  logic [N-1:0]  root_s [N+1];
  logic [SW-1:0] sb_s   [N+1];

  assign x_s[0]    = in_x;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign sb_s[0]   = in_sb;

  for (genvar g = 0; g < N; g++) begin : g_step
    logic [N+1:0] rem_sh;
    logic [N+1:0] trial;
    logic         ge;

    assign rem_sh = {rem_s[g][N-1:0], x_s[g][W-1:W-2]};
    assign trial  = {root_s[g], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sb_s[g+1] <= '0;
      end else if (en) begin
        sb_s[g+1] <= sb_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_s[g+1]    <= x_s[g] << 2;
        rem_s[g+1]  <= ge ? rem_sh - trial : rem_sh;
        root_s[g+1] <= {root_s[g][N-2:0], ge};
      end
    end
  end

  assign root   = root_s[N];
  assign out_sb = sb_s[N];

endmodule
`default_nettype wire

>>> rtl/tsd_depth.sv
`default_nettype none
module tsd_depth #(
  parameter int DEPTH_LIMIT = tsd_pkg::DEPTH_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic        far,
  input  wire logic [31:0] edge_len,
  input  wire logic [12:0] droot,
  input  wire logic [23:0] min_edge,
  input  wire logic [19:0] safe_per_edge,
  input  wire logic [15:0] margin,
  output logic             out_valid,
  output logic [3:0]       split_depth
);
  import tsd_pkg::*;

  logic               vld_a;
  logic               far_a;
  logic signed [24:0] dm_a;
  logic [51:0]        prod_a;
  logic [31:0]        edge_a;
  logic [3:0]         depth_c;

  always_comb begin
    logic               ok;
    logic [39:0]        min_sh;
    logic signed [63:0] lhs;
    depth_c = '0;
    ok      = 1'b1;
    for (int k = 0; k < DEPTH_LIMIT; k++) begin
      min_sh  = {16'b0, min_edge} << k;
      lhs     = 64'(dm_a) <<< (12 + k);
      ok      = ok && ({8'b0, edge_a} > min_sh) && (lhs < $signed({12'b0, prod_a}));
      depth_c = depth_c + {3'b000, ok};
    end
    if (far_a) depth_c = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_a     <= in_valid;
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far_a       <= far;
      dm_a        <= $signed({1'b0, droot, 10'b0}) - $signed({9'b0, margin});
      prod_a      <= 52'(safe_per_edge) * 52'(edge_len);
      edge_a      <= edge_len;
      split_depth <= depth_c;
    end
  end

endmodule
`default_nettype wire

>>> rtl/triangle_subdivision_depth_unit.sv
// Throughput: one triangle per cycle while the result is not stalled, through a
// fully pipelined datapath; the two 32-stage square-root pipes set the depth.
// A stalled result holds the whole pipeline.
// Synchronous reset empties the pipeline and loads the register defaults.
`default_nettype none
module triangle_subdivision_depth_unit #(
  parameter int DEPTH_LIMIT = tsd_pkg::DEPTH_LIMIT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [31:0]           eye_x,
  input  wire logic signed [31:0]           eye_y,
  input  wire logic signed [31:0]           eye_z,
  input  wire logic signed [31:0]           va_x,
  input  wire logic signed [31:0]           va_y,
  input  wire logic signed [31:0]           va_z,
  input  wire logic signed [31:0]           vb_x,
  input  wire logic signed [31:0]           vb_y,
  input  wire logic signed [31:0]           vb_z,
  input  wire logic signed [31:0]           vc_x,
  input  wire logic signed [31:0]           vc_y,
  input  wire logic signed [31:0]           vc_z,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [3:0]                        split_depth,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tsd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import tsd_pkg::*;

  logic [23:0] min_edge;
  logic [19:0] safe_per_edge;
  logic [15:0] margin;
  logic [13:0] reach_scale;
  logic [33:0] cfg_prod;
  logic [22:0] reach;
  logic [45:0] reach2;
  tsd_reg_t    reg_sel;

  logic   en;
  coord_t eye [3];
  coord_t va  [3];
  coord_t vb  [3];
  coord_t vc  [3];

  logic        f_valid;
  logic        f_far;
  logic [63:0] f_e2max;
  logic [25:0] f_d2hi;
  logic [31:0] edge_root;
  logic [31:0] d_root;
  logic        s_valid;
  logic        s_far;

  assign pready  = 1'b1;
  assign reg_sel = tsd_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_edge      <= MIN_EDGE_RST;
      safe_per_edge <= SAFE_RST;
      margin        <= MARGIN_RST;
      reach_scale   <= SOURCE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_MIN_EDGE:      min_edge      <= pwdata[23:0];
        REG_SAFE_PER_EDGE: safe_per_edge <= pwdata[19:0];
        REG_MARGIN:        margin        <= pwdata[15:0];
        REG_REACH_SCALE:   reach_scale   <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_EDGE:      prdata = {8'b0, min_edge};
      REG_SAFE_PER_EDGE: prdata = {12'b0, safe_per_edge};
      REG_MARGIN:        prdata = {16'b0, margin};
      REG_REACH_SCALE:   prdata = {18'b0, reach_scale};
      default:           prdata = '0;
    endcase
  end

  assign reach = 23'(cfg_prod[33:12]) + 23'(margin);

  always_ff @(posedge clk) begin
    cfg_prod <= 34'(safe_per_edge) * 34'(reach_scale);
    reach2   <= 46'(reach) * 46'(reach);
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign eye = '{eye_x, eye_y, eye_z};
  assign va  = '{va_x, va_y, va_z};
  assign vb  = '{vb_x, vb_y, vb_z};
  assign vc  = '{vc_x, vc_y, vc_z};

  tsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .eye       (eye),
    .va        (va),
    .vb        (vb),
    .vc        (vc),
    .reach2    (reach2),
    .out_valid (f_valid),
    .far       (f_far),
    .e2max     (f_e2max),
    .d2hi      (f_d2hi)
  );

  tsd_isqrt #(.W(64), .SW(1)) u_edge_sqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_x   (f_e2max),
    .in_sb  (f_valid),
    .root   (edge_root),
    .out_sb (s_valid)
  );

  tsd_isqrt #(.W(64), .SW(1)) u_dist_sqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_x   ({38'b0, f_d2hi}),
    .in_sb  (f_far),
    .root   (d_root),
    .out_sb (s_far)
  );

  tsd_depth #(.DEPTH_LIMIT(DEPTH_LIMIT)) u_depth (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (s_valid),
    .far           (s_far),
    .edge_len      (edge_root),
    .droot         (d_root[12:0]),
    .min_edge      (min_edge),
    .safe_per_edge (safe_per_edge),
    .margin        (margin),
    .out_valid     (out_valid),
    .split_depth   (split_depth)
  );

endmodule
`default_nettype wire
